// ===== design/dwpi_pkg.sv =====
package dwpi_pkg;

    localparam int SPEED_BITS_DEF = 16;

    localparam int DRIVE_W    = 16;
    localparam int SUM_W      = 17;
    localparam int EXTRA_BITS = 8;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    // Feedforward curve in Q23 power: two slopes with a break point.
    localparam int FF_BREAK     = 30;
    localparam int FF_SLOPE_HI  = 26256;
    localparam int FF_OFFSET_HI = 478151;
    localparam int FF_SLOPE_LO  = 55924;

    localparam logic        ENABLE_RST      = 1'b1;
    localparam logic [15:0] PROP_GAIN_RST   = 16'd4194;
    localparam logic [15:0] INTEG_GAIN_RST  = 16'd419;
    localparam logic [15:0] SUM_LIMIT_RST   = 16'd5000;
    localparam logic [9:0]  STOP_THRESH_RST = 10'd2;
    localparam logic [14:0] POWER_LIMIT_RST = 15'd32767;

    typedef struct packed {
        logic        enable;
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] sum_limit_left;
        logic [15:0] sum_limit_right;
        logic [9:0]  stop_threshold;
        logic [14:0] power_limit;
    } cfg_t;

    typedef struct packed {
        logic a_load;
        logic b_load;
        logic c_load;
        logic d_load;
        logic commit;
    } pipe_ctl_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] power;
        logic                      want_zero;
    } lane_res_t;

endpackage

// ===== design/dwpi_regs.sv =====
module dwpi_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dwpi_pkg::ADDR_W-1:0]   paddr,
    input  logic [dwpi_pkg::DATA_W-1:0]   pwdata,
    output logic [dwpi_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output dwpi_pkg::cfg_t                cfg
);
    import dwpi_pkg::*;

    typedef enum logic [2:0] {
        REG_ENABLE      = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_SUM_LIM_L   = 3'd3,
        REG_SUM_LIM_R   = 3'd4,
        REG_STOP_THRESH = 3'd5,
        REG_POWER_LIMIT = 3'd6
    } reg_idx_t;

    cfg_t cfg_reg;
    logic wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable          <= ENABLE_RST;
            cfg_reg.prop_gain       <= PROP_GAIN_RST;
            cfg_reg.integ_gain      <= INTEG_GAIN_RST;
            cfg_reg.sum_limit_left  <= SUM_LIMIT_RST;
            cfg_reg.sum_limit_right <= SUM_LIMIT_RST;
            cfg_reg.stop_threshold  <= STOP_THRESH_RST;
            cfg_reg.power_limit     <= POWER_LIMIT_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_ENABLE:      cfg_reg.enable          <= pwdata[0];
                REG_PROP_GAIN:   cfg_reg.prop_gain       <= pwdata[15:0];
                REG_INTEG_GAIN:  cfg_reg.integ_gain      <= pwdata[15:0];
                REG_SUM_LIM_L:   cfg_reg.sum_limit_left  <= pwdata[15:0];
                REG_SUM_LIM_R:   cfg_reg.sum_limit_right <= pwdata[15:0];
                REG_STOP_THRESH: cfg_reg.stop_threshold  <= pwdata[9:0];
                REG_POWER_LIMIT: cfg_reg.power_limit     <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ENABLE:      prdata = DATA_W'(cfg_reg.enable);
            REG_PROP_GAIN:   prdata = DATA_W'(cfg_reg.prop_gain);
            REG_INTEG_GAIN:  prdata = DATA_W'(cfg_reg.integ_gain);
            REG_SUM_LIM_L:   prdata = DATA_W'(cfg_reg.sum_limit_left);
            REG_SUM_LIM_R:   prdata = DATA_W'(cfg_reg.sum_limit_right);
            REG_STOP_THRESH: prdata = DATA_W'(cfg_reg.stop_threshold);
            REG_POWER_LIMIT: prdata = DATA_W'(cfg_reg.power_limit);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== design/dwpi_lane.sv =====
module dwpi_lane #(
    parameter int SPEED_BITS = dwpi_pkg::SPEED_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dwpi_pkg::pipe_ctl_t           ctl,
    input  dwpi_pkg::cfg_t                cfg,
    input  logic [15:0]                   sum_limit,
    input  logic signed [SPEED_BITS-1:0]  want,
    input  logic signed [SPEED_BITS-1:0]  seen,
    input  logic                          clear,
    output dwpi_pkg::lane_res_t           res
);
    import dwpi_pkg::*;

    localparam int ERR_W  = SPEED_BITS + 1;
    localparam int CMP_W  = (SPEED_BITS > 10) ? SPEED_BITS : 10;
    localparam int FF_W   = SPEED_BITS + 17;
    localparam int P_W    = ERR_W + 17;
    localparam int I_W    = SUM_W + 17;
    localparam int WIDE   = (SPEED_BITS > 16) ? SPEED_BITS : 16;
    localparam int TOT_W  = WIDE + 19;
    localparam int M_W    = TOT_W - EXTRA_BITS;
    localparam int SUMX_W = ((ERR_W > SUM_W) ? ERR_W : SUM_W) + 1;

    // Stage A: feedforward and proportional products.
    logic [SPEED_BITS-1:0]    want_u, seen_u, want_mag, seen_mag;
    logic                     ff_hi;
    logic [15:0]              slope;
    logic [FF_W-1:0]          ff_mag_next;
    logic signed [ERR_W-1:0]  err_next;
    logic signed [P_W-1:0]    p_next;
    logic                     stop_next;

    logic [FF_W-1:0]          ff_mag_a_reg;
    logic                     ff_neg_a_reg;
    logic signed [ERR_W-1:0]  err_a_reg, err_b_reg, err_c_reg, err_d_reg;
    logic signed [P_W-1:0]    p_a_reg;
    logic                     stop_a_reg, stop_b_reg, stop_c_reg, stop_d_reg;
    logic                     wz_a_reg, wz_b_reg, wz_c_reg, wz_d_reg;

    assign want_u   = want;
    assign seen_u   = seen;
    assign want_mag = want[SPEED_BITS-1] ? (~want_u + 1'b1) : want_u;
    assign seen_mag = seen[SPEED_BITS-1] ? (~seen_u + 1'b1) : seen_u;
    assign ff_hi    = CMP_W'(want_mag) > CMP_W'(FF_BREAK);
    assign slope    = ff_hi ? 16'(FF_SLOPE_HI) : 16'(FF_SLOPE_LO);
    assign ff_mag_next = FF_W'(want_mag) * FF_W'(slope)
                       + (ff_hi ? FF_W'(FF_OFFSET_HI) : FF_W'(0));
    assign err_next  = ERR_W'(want) - ERR_W'(seen);
    assign p_next    = $signed({1'b0, cfg.prop_gain}) * err_next;
    assign stop_next = (CMP_W'(want_mag) <= CMP_W'(cfg.stop_threshold))
                    && (CMP_W'(seen_mag) <= CMP_W'(cfg.stop_threshold));

    always_ff @(posedge aclk) begin
        if (ctl.a_load) begin
            ff_mag_a_reg <= ff_mag_next;
            ff_neg_a_reg <= want[SPEED_BITS-1];
            err_a_reg    <= err_next;
            p_a_reg      <= p_next;
            stop_a_reg   <= stop_next;
            wz_a_reg     <= (want == '0);
        end
    end

    // Stage B: signed feedforward plus proportional, and the integral product.
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [FF_W:0]     ff_s;
    logic signed [TOT_W-1:0]  part_next, part_b_reg;
    logic signed [I_W-1:0]    i_next, i_b_reg;

    assign ff_s      = ff_neg_a_reg ? -$signed({1'b0, ff_mag_a_reg})
                                    :  $signed({1'b0, ff_mag_a_reg});
    assign part_next = TOT_W'(ff_s) + TOT_W'(p_a_reg);
    assign i_next    = $signed({1'b0, cfg.integ_gain}) * sum_reg;

    always_ff @(posedge aclk) begin
        if (ctl.b_load) begin
            part_b_reg <= part_next;
            i_b_reg    <= i_next;
            err_b_reg  <= err_a_reg;
            stop_b_reg <= stop_a_reg;
            wz_b_reg   <= wz_a_reg;
        end
    end

    // Stage C: total in Q23.
    logic signed [TOT_W-1:0] tot_next, tot_c_reg;

    assign tot_next = part_b_reg + TOT_W'(i_b_reg);

    always_ff @(posedge aclk) begin
        if (ctl.c_load) begin
            tot_c_reg  <= tot_next;
            err_c_reg  <= err_b_reg;
            stop_c_reg <= stop_b_reg;
            wz_c_reg   <= wz_b_reg;
        end
    end

    // Stage D: magnitude rounded to Q15, halves away from zero.
    logic [TOT_W-1:0] tot_u, tot_abs, tot_rnd;
    logic [M_W-1:0]   m_d_reg;
    logic             neg_d_reg;

    assign tot_u   = tot_c_reg;
    assign tot_abs = tot_c_reg[TOT_W-1] ? (~tot_u + 1'b1) : tot_u;
    assign tot_rnd = tot_abs + TOT_W'(1 << (EXTRA_BITS - 1));

    always_ff @(posedge aclk) begin
        if (ctl.d_load) begin
            m_d_reg    <= tot_rnd[TOT_W-1:EXTRA_BITS];
            neg_d_reg  <= tot_c_reg[TOT_W-1];
            err_d_reg  <= err_c_reg;
            stop_d_reg <= stop_c_reg;
            wz_d_reg   <= wz_c_reg;
        end
    end

    // Commit: clip, stop override and anti-windup error sum update.
    logic                      below;
    logic [14:0]               mag_clip;
    logic signed [DRIVE_W-1:0] pw;
    logic                      integ;
    logic signed [SUM_W-1:0]   base, sum_next;
    logic signed [SUMX_W-1:0]  sx, slim_x, sclip;

    assign below    = m_d_reg < M_W'(cfg.power_limit);
    assign mag_clip = below ? m_d_reg[14:0] : cfg.power_limit;
    always_comb begin
        if (stop_d_reg) begin
            pw = '0;
        end else if (neg_d_reg) begin
            pw = -$signed({1'b0, mag_clip});
        end else begin
            pw = $signed({1'b0, mag_clip});
        end
    end

    // A stopped wheel has zero power, which is below any nonzero limit.
    assign integ  = stop_d_reg ? (cfg.power_limit != '0) : below;
    assign base   = stop_d_reg ? '0 : sum_reg;
    assign sx     = SUMX_W'(base) + SUMX_W'(err_d_reg);
    assign slim_x = SUMX_W'($signed({1'b0, sum_limit}));
    always_comb begin
        if (sx > slim_x) begin
            sclip = slim_x;
        end else if (sx < -slim_x) begin
            sclip = -slim_x;
        end else begin
            sclip = sx;
        end
    end
    assign sum_next = integ ? SUM_W'(sclip) : base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctl.commit) begin
            sum_reg <= clear ? '0 : sum_next;
        end
    end

    assign res.power     = pw;
    assign res.want_zero = wz_d_reg;

    // A saturated wheel keeps its sum, so only an integrating commit is bounded.
    a_sum_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.commit && integ && !clear |=>
            (SUMX_W'(sum_reg) <= $past(slim_x)) && (SUMX_W'(sum_reg) >= -$past(slim_x)))
        else $error("error sum outside its limit after commit");

    a_clear_zeroes_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.commit && clear |=> sum_reg == '0)
        else $error("error sum not cleared");

    a_stop_zero_power: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.commit && stop_d_reg |-> pw == '0)
        else $error("stopped wheel given power");

endmodule

// ===== design/dwpi_merge.sv =====
module dwpi_merge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                commit,
    input  logic                                enable,
    input  dwpi_pkg::lane_res_t                 res_l,
    input  dwpi_pkg::lane_res_t                 res_r,
    input  logic                                m_ready,
    output logic                                clear,
    output logic                                m_valid,
    output logic signed [dwpi_pkg::DRIVE_W-1:0] m_drive_left,
    output logic signed [dwpi_pkg::DRIVE_W-1:0] m_drive_right,
    output logic                                m_wheels_powered
);
    import dwpi_pkg::*;

    logic                      valid_reg;
    logic signed [DRIVE_W-1:0] drive_l_reg, drive_r_reg, drive_l_next, drive_r_next;
    logic                      powered_reg;

    // The output registers double as the last drives for the coast check.
    assign clear = !enable
                || (res_l.want_zero && res_r.want_zero
                    && drive_l_reg == '0 && drive_r_reg == '0);
    assign drive_l_next = clear ? '0 : res_l.power;
    assign drive_r_next = clear ? '0 : res_r.power;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            drive_l_reg <= '0;
            drive_r_reg <= '0;
            powered_reg <= 1'b0;
        end else if (commit) begin
            valid_reg   <= 1'b1;
            drive_l_reg <= drive_l_next;
            drive_r_reg <= drive_r_next;
            powered_reg <= (drive_l_next != '0) || (drive_r_next != '0);
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign m_valid          = valid_reg;
    assign m_drive_left     = drive_l_reg;
    assign m_drive_right    = drive_r_reg;
    assign m_wheels_powered = powered_reg;

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> valid_reg)
        else $error("committed item not presented");

    a_disabled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && !enable |=> drive_l_reg == '0 && drive_r_reg == '0 && !powered_reg)
        else $error("power given while disabled");

    a_powered_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> powered_reg == (drive_l_reg != '0 || drive_r_reg != '0))
        else $error("powered flag disagrees with drives");

endmodule

// ===== design/dual_wheel_pi_speed_controller_top.sv =====
// An accepted item passes stages A, B, C and D and then commits to the output registers.
// Items enter stage B one at a time, held back by the error sum loop: the integral
// multiply of an item reads the sums only after the previous item has committed.
// One item may wait in the first stage while another is in flight or its result waits.
// Reset: aresetn is synchronous and active low; registers go to their defaults,
// error sums and last drives to zero. No clearing pass is needed.
module dual_wheel_pi_speed_controller_top #(
    parameter int SPEED_BITS = dwpi_pkg::SPEED_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dwpi_pkg::ADDR_W-1:0]         paddr,
    input  logic [dwpi_pkg::DATA_W-1:0]         pwdata,
    output logic [dwpi_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SPEED_BITS-1:0]        s_want_left,
    input  logic signed [SPEED_BITS-1:0]        s_want_right,
    input  logic signed [SPEED_BITS-1:0]        s_seen_left,
    input  logic signed [SPEED_BITS-1:0]        s_seen_right,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dwpi_pkg::DRIVE_W-1:0] m_drive_left,
    output logic signed [dwpi_pkg::DRIVE_W-1:0] m_drive_right,
    output logic                                m_wheels_powered
);
    import dwpi_pkg::*;

    cfg_t      cfg;
    pipe_ctl_t ctl;
    lane_res_t res_l, res_r;
    logic      clear;
    logic      va_reg, vb_reg, vc_reg, vd_reg;

    dwpi_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Only one item is past the first stage at a time.
    assign ctl.commit = vd_reg && (!m_valid || m_ready);
    assign ctl.d_load = vc_reg && (!vd_reg || ctl.commit);
    assign ctl.c_load = vb_reg && (!vc_reg || ctl.d_load);
    assign ctl.b_load = va_reg && !vb_reg && !vc_reg && !vd_reg;
    assign s_ready    = !va_reg || ctl.b_load;
    assign ctl.a_load = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            va_reg <= ctl.a_load || (va_reg && !ctl.b_load);
            vb_reg <= ctl.b_load || (vb_reg && !ctl.c_load);
            vc_reg <= ctl.c_load || (vc_reg && !ctl.d_load);
            vd_reg <= ctl.d_load || (vd_reg && !ctl.commit);
        end
    end

    dwpi_lane #(.SPEED_BITS(SPEED_BITS)) u_lane_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .cfg       (cfg),
        .sum_limit (cfg.sum_limit_left),
        .want      (s_want_left),
        .seen      (s_seen_left),
        .clear     (clear),
        .res       (res_l)
    );

    dwpi_lane #(.SPEED_BITS(SPEED_BITS)) u_lane_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .cfg       (cfg),
        .sum_limit (cfg.sum_limit_right),
        .want      (s_want_right),
        .seen      (s_seen_right),
        .clear     (clear),
        .res       (res_r)
    );

    dwpi_merge u_merge (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .commit           (ctl.commit),
        .enable           (cfg.enable),
        .res_l            (res_l),
        .res_r            (res_r),
        .m_ready          (m_ready),
        .clear            (clear),
        .m_valid          (m_valid),
        .m_drive_left     (m_drive_left),
        .m_drive_right    (m_drive_right),
        .m_wheels_powered (m_wheels_powered)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({vb_reg, vc_reg, vd_reg}))
        else $error("more than one item past the first stage");

    a_b_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        vb_reg |=> !vb_reg && vc_reg)
        else $error("item stuck in integral stage");

    a_drain_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        vd_reg && !m_valid |=> !vd_reg && m_valid)
        else $error("finished item not committed to a free output");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

typedef enum int {
    REG_ENABLE      = 0,
    REG_PROP_GAIN   = 1,
    REG_INTEG_GAIN  = 2,
    REG_SUM_LIMIT_L = 3,
    REG_SUM_LIMIT_R = 4,
    REG_STOP_THRESH = 5,
    REG_POWER_LIMIT = 6
} reg_id_e;

typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               powered;
} power_set_t;

// Tracks the controller state and holds the motor powers still due.
class power_tracker;
    dwpi_pkg::cfg_t cfg;
    longint         sum_l;
    longint         sum_r;
    longint         last_l;
    longint         last_r;
    power_set_t     due_powers[$];
    int             mismatches;
    int             checked;

    function new();
        cfg.enable          = dwpi_pkg::ENABLE_RST;
        cfg.prop_gain       = dwpi_pkg::PROP_GAIN_RST;
        cfg.integ_gain      = dwpi_pkg::INTEG_GAIN_RST;
        cfg.sum_limit_left  = dwpi_pkg::SUM_LIMIT_RST;
        cfg.sum_limit_right = dwpi_pkg::SUM_LIMIT_RST;
        cfg.stop_threshold  = dwpi_pkg::STOP_THRESH_RST;
        cfg.power_limit     = dwpi_pkg::POWER_LIMIT_RST;
        sum_l = 0;
        sum_r = 0;
        last_l = 0;
        last_r = 0;
        mismatches = 0;
        checked = 0;
    endfunction

    function void set_reg(reg_id_e id, logic [31:0] v);
        case (id)
            REG_ENABLE:      cfg.enable = v[0];
            REG_PROP_GAIN:   cfg.prop_gain = v[15:0];
            REG_INTEG_GAIN:  cfg.integ_gain = v[15:0];
            REG_SUM_LIMIT_L: cfg.sum_limit_left = v[15:0];
            REG_SUM_LIMIT_R: cfg.sum_limit_right = v[15:0];
            REG_STOP_THRESH: cfg.stop_threshold = v[9:0];
            REG_POWER_LIMIT: cfg.power_limit = v[14:0];
            default: ;
        endcase
    endfunction

    function longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Feedforward plus PI for one wheel; the power is in Q15 and the sum is updated.
    function logic signed [15:0] wheel_power(longint want, longint seen, inout longint acc,
                                             input longint slim);
        longint x, err, ff, tot, m, pw, s, plim, stop;
        x = mag(want);
        err = want - seen;
        s = acc;
        plim = longint'(cfg.power_limit);
        stop = longint'(cfg.stop_threshold);
        if (x > dwpi_pkg::FF_BREAK)
            ff = x * dwpi_pkg::FF_SLOPE_HI + dwpi_pkg::FF_OFFSET_HI;
        else
            ff = x * dwpi_pkg::FF_SLOPE_LO;
        if (want < 0)
            ff = -ff;
        tot = ff + longint'(cfg.prop_gain) * err + longint'(cfg.integ_gain) * s;
        // Round the magnitude to nearest, halves away from zero.
        m = (mag(tot) + (longint'(1) << (dwpi_pkg::EXTRA_BITS - 1))) >> dwpi_pkg::EXTRA_BITS;
        pw = clip((tot < 0) ? -m : m, plim);
        if (x <= stop && mag(seen) <= stop) begin
            pw = 0;
            s = 0;
        end
        // The sum integrates only while the wheel is below the power limit.
        if (mag(pw) < plim)
            s = clip(s + err, slim);
        acc = s;
        return 16'(pw);
    endfunction

    function void note_speeds(logic signed [15:0] wl, wr, sl, sr);
        power_set_t p;
        p.left = '0;
        p.right = '0;
        if (!cfg.enable) begin
            sum_l = 0;
            sum_r = 0;
        end else if (wl == 0 && wr == 0 && last_l == 0 && last_r == 0) begin
            sum_l = 0;
            sum_r = 0;
        end else begin
            p.left = wheel_power(longint'(wl), longint'(sl), sum_l,
                                 longint'(cfg.sum_limit_left));
            p.right = wheel_power(longint'(wr), longint'(sr), sum_r,
                                  longint'(cfg.sum_limit_right));
        end
        last_l = longint'(p.left);
        last_r = longint'(p.right);
        p.powered = (p.left != 0 || p.right != 0);
        due_powers.push_back(p);
    endfunction

    function void note_miss(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at result %0d: %s", checked, msg);
    endfunction

    function void check_powers(logic signed [15:0] l, r, logic p);
        power_set_t exp_p;
        checked++;
        if (due_powers.size() == 0) begin
            note_miss($sformatf("unexpected item drive %0d %0d powered %0b", l, r, p));
            return;
        end
        exp_p = due_powers.pop_front();
        if (exp_p.left !== l || exp_p.right !== r || exp_p.powered !== p)
            note_miss($sformatf("expected drive %0d %0d powered %0b, got %0d %0d %0b",
                                exp_p.left, exp_p.right, exp_p.powered, l, r, p));
    endfunction

    function int outstanding();
        return due_powers.size();
    endfunction
endclass

module tb_top;

    logic                               aclk;
    logic                               aresetn;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [dwpi_pkg::ADDR_W-1:0]        paddr;
    logic [dwpi_pkg::DATA_W-1:0]        pwdata;
    logic [dwpi_pkg::DATA_W-1:0]        prdata;
    logic                               pready;
    logic                               s_valid;
    logic                               s_ready;
    logic signed [15:0]                 s_want_left;
    logic signed [15:0]                 s_want_right;
    logic signed [15:0]                 s_seen_left;
    logic signed [15:0]                 s_seen_right;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [dwpi_pkg::DRIVE_W-1:0] m_drive_left;
    logic signed [dwpi_pkg::DRIVE_W-1:0] m_drive_right;
    logic                               m_wheels_powered;

    power_tracker board;
    int           send_idle_pct = 12;
    int           recv_idle_pct = 58;
    bit           want_hold = 1'b0;
    int           traj_l = 0;
    int           traj_r = 0;

    dual_wheel_pi_speed_controller_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_want_left      (s_want_left),
        .s_want_right     (s_want_right),
        .s_seen_left      (s_seen_left),
        .s_seen_right     (s_seen_right),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_left     (m_drive_left),
        .m_drive_right    (m_drive_right),
        .m_wheels_powered (m_wheels_powered)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic logic signed [15:0] sat16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic int spread(int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    task automatic write_reg(reg_id_e id, logic [31:0] v);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dwpi_pkg::ADDR_W'(4 * int'(id));
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(id, v);
    endtask

    task automatic apply_cfg(logic [31:0] en, kp, ki, lim_l, lim_r, stop, plim);
        write_reg(REG_ENABLE, en);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_SUM_LIMIT_L, lim_l);
        write_reg(REG_SUM_LIMIT_R, lim_r);
        write_reg(REG_STOP_THRESH, stop);
        write_reg(REG_POWER_LIMIT, plim);
    endtask

    task automatic send_speeds(logic signed [15:0] wl, wr, sl, sr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_want_left  <= wl;
        s_want_right <= wr;
        s_seen_left  <= sl;
        s_seen_right <= sr;
        do @(posedge aclk); while (!s_ready);
        board.note_speeds(wl, wr, sl, sr);
    endtask

    // Stops offering items and waits for every due result, plus the pipeline depth.
    task automatic settle();
        s_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Mostly smooth speed tracks with measured speed near the target; the rest is
    // full-range noise, speeds around the stop threshold and zero targets.
    task automatic make_speeds(int scale, output logic signed [15:0] wl, wr, sl, sr);
        int pick;
        int near;
        pick = $urandom_range(99);
        near = int'(board.cfg.stop_threshold) + 3;
        if (pick < 18) begin
            wl = 16'($urandom);
            wr = 16'($urandom);
            sl = 16'($urandom);
            sr = 16'($urandom);
        end else if (pick < 28) begin
            wl = sat16(spread(near));
            wr = sat16(spread(near));
            sl = sat16(spread(near));
            sr = sat16(spread(near));
        end else if (pick < 36) begin
            wl = '0;
            wr = '0;
            sl = sat16(spread(near));
            sr = sat16(spread(near));
        end else begin
            if ($urandom_range(4) == 0) begin
                traj_l = spread(scale);
                traj_r = spread(scale);
            end
            wl = sat16(traj_l);
            wr = sat16(traj_r);
            sl = sat16(traj_l + spread(40));
            sr = sat16(traj_r + spread(40));
        end
    endtask

    // Receiver: random back-pressure plus one long hold-off on request.
    initial begin
        int hold_cnt;
        bit hold_taken;
        hold_cnt = 0;
        hold_taken = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                board.check_powers(m_drive_left, m_drive_right, m_wheels_powered);
            if (want_hold && !hold_taken) begin
                hold_taken = 1'b1;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic signed [15:0] wl, wr, sl, sr;
        int scales[8];
        board = new();
        scales = '{800, 2000, 30000, 1200, 800, 600, 4000, 800};
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_want_left  = '0;
        s_want_right = '0;
        s_seen_left  = '0;
        s_seen_right = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: coasting, extremes, the feedforward break, stop threshold.
        send_speeds(0, 0, 0, 0);
        send_speeds(32767, -32768, -32768, 32767);
        send_speeds(-32768, 32767, 32767, -32768);
        send_speeds(30, 31, 30, 31);
        send_speeds(-30, -31, -29, -33);
        send_speeds(2, -2, -2, 2);
        send_speeds(3, 2, 2, 3);
        send_speeds(0, 0, 100, -100);
        send_speeds(0, 0, 0, 0);
        send_speeds(0, 0, 50, -50);
        send_speeds(1000, -1000, 0, 0);
        repeat (3) send_speeds(100, -100, 95, -105);
        settle();

        // A gain of 128 in Q23 is half a Q15 step per unit of error, so odd errors land exactly on a half.
        apply_cfg(1, 128, 0, 5000, 5000, 0, 32767);
        send_speeds(0, 5, -1, 5);
        send_speeds(0, 5, 1, 5);
        send_speeds(0, 5, -3, 5);
        send_speeds(0, -5, 3, -5);
        settle();

        apply_cfg(0, 4194, 419, 5000, 5000, 2, 32767);
        send_speeds(500, -500, 0, 0);
        send_speeds(0, 0, 0, 0);
        settle();

        for (int p = 0; p < 8; p++) begin
            send_idle_pct = (p < 3) ? 12 : (p < 6) ? 58 : 0;
            recv_idle_pct = (p < 3) ? 58 : (p < 6) ? 12 : 0;
            case (p)
                0: apply_cfg(1, 4194, 419, 5000, 5000, 2, 32767);
                1: apply_cfg(1, 0, 0, 0, 0, 0, 0);
                2: apply_cfg(1, 65535, 65535, 65535, 65535, 1023, 32767);
                3: apply_cfg(1, $urandom_range(8000), $urandom_range(2000),
                             $urandom_range(65535), $urandom_range(200),
                             $urandom_range(40), $urandom_range(32767));
                4: apply_cfg(0, $urandom_range(65535), $urandom_range(65535),
                             $urandom_range(65535), $urandom_range(65535),
                             $urandom_range(1023), $urandom_range(32767));
                5: apply_cfg(1, 300, 20000, 100, 37, 5, 20000);
                6: apply_cfg(1, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
                default: apply_cfg(1, 4194, 419, 5000, 5000, 2, 32767);
            endcase
            for (int i = 0; i < 175; i++) begin
                if (p == 1 && i == 40)
                    want_hold = 1'b1;
                if (p == 4 && i == 90)
                    settle();
                make_speeds(scales[p], wl, wr, sl, sr);
                send_speeds(wl, wr, sl, sr);
            end
            settle();
        end

        repeat (20) @(posedge aclk);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dwpi_pkg.sv
design/dwpi_regs.sv
design/dwpi_lane.sv
design/dwpi_merge.sv
design/dual_wheel_pi_speed_controller_top.sv
test/tb_top.sv
